>>> hdl/counting_semaphore_table_unit_assert.svh
// assertion macros for the counting semaphore table
`ifndef COUNTING_SEMAPHORE_TABLE_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_UNIT_ASSERT_SVH

// checked property, off while reset is high
`define CSEM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, also during reset
`define CSEM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/csem_pkg.sv
// shared types and constants for the counting semaphore table
`default_nettype none
package csem_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = 4;
   localparam int COUNT_BITS = 16;
   localparam int TASK_BITS  = 8;
   localparam int TICK_BITS  = 32;

   localparam logic [1:0] CMD_CREATE  = 2'd0;
   localparam logic [1:0] CMD_TAKE    = 2'd1;
   localparam logic [1:0] CMD_GIVE    = 2'd2;
   localparam logic [1:0] CMD_DESTROY = 2'd3;

   localparam logic [1:0] WAIT_NONE    = 2'd0;
   localparam logic [1:0] WAIT_BOUNDED = 2'd1;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_NOMEM    = 3'd2;
   localparam logic [2:0] ST_BUSY     = 3'd3;
   localparam logic [2:0] ST_TIMEOUT  = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;
   localparam logic [2:0] ST_PENDING  = 3'd6;

   typedef struct packed {
      logic [TASK_BITS-1:0]  task_id;
      logic [TICK_BITS-1:0]  elapsed_ticks;
      logic [TICK_BITS-1:0]  tick_limit;
      logic [1:0]            wait_mode;
      logic [COUNT_BITS-1:0] ceil_count;
      logic [COUNT_BITS-1:0] init_count;
      logic [SLOT_BITS-1:0]  handle;
      logic [1:0]            cmd;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count_now;
      logic [TASK_BITS-1:0]  wake_task;
      logic                  woke_waiter;
      logic [SLOT_BITS-1:0]  new_handle;
      logic [2:0]            status;
   } rsp_type;

   typedef struct packed {
      logic [TASK_BITS-1:0]  wait_task;
      logic [COUNT_BITS-1:0] ceiling;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] addr;
      entry_type            data;
   } mem_wr_type;

endpackage
`default_nettype wire

>>> hdl/csem_store.sv
// slot memory: count, ceiling and waiting task per slot, registered read
`default_nettype none
module csem_store
   import csem_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [SLOT_BITS-1:0] rd_addr,
   output entry_type                 rd_data,
   input  wire mem_wr_type           wr
);

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/csem_engine.sv
// command sequencer: slot flags, free-slot search and read-modify-write
`default_nettype none
module csem_engine
   import csem_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req,
   input  wire logic                 out_free,
   output logic                      res_valid,
   output rsp_type                   res,
   output logic                      rd_en,
   output logic [SLOT_BITS-1:0]      rd_addr,
   input  wire entry_type            rd_data,
   output mem_wr_type                wr
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   req_type              req_ff, req_in;
   logic [SLOTS-1:0]     used_ff, used_in;
   logic [SLOTS-1:0]     waiting_ff, waiting_in;

   logic                 accept;
   logic                 fire;
   logic                 has_free;
   logic [SLOT_BITS-1:0] free_idx;
   logic                 slot_ok;
   logic                 args_ok;
   rsp_type              res_c;
   mem_wr_type           wr_c;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == ST_EXEC) && out_free;
   assign rd_en     = accept;
   assign rd_addr   = req.handle;
   assign slot_ok   = used_ff[req_ff.handle];
   assign args_ok   = (req_ff.ceil_count != '0) && (req_ff.init_count <= req_ff.ceil_count);

   // lowest free slot
   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            has_free = 1'b1;
            free_idx = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      res_c          = '0;
      res_c.status   = ST_INVALID;
      wr_c.en        = 1'b0;
      wr_c.addr      = req_ff.handle;
      wr_c.data      = rd_data;
      used_in        = used_ff;
      waiting_in     = waiting_ff;
      unique case (req_ff.cmd)
         CMD_CREATE: begin
            if (args_ok) begin
               res_c.status = ST_NOMEM;
               if (has_free) begin
                  res_c.status         = ST_OK;
                  res_c.new_handle     = free_idx;
                  res_c.count_now      = req_ff.init_count;
                  wr_c.en              = 1'b1;
                  wr_c.addr            = free_idx;
                  wr_c.data.count      = req_ff.init_count;
                  wr_c.data.ceiling    = req_ff.ceil_count;
                  wr_c.data.wait_task  = '0;
                  used_in[free_idx]    = 1'b1;
                  waiting_in[free_idx] = 1'b0;
               end
            end
         end
         CMD_TAKE: begin
            if (slot_ok) begin
               res_c.count_now = rd_data.count;
               if (rd_data.count != '0) begin
                  res_c.status    = ST_OK;
                  res_c.count_now = rd_data.count - COUNT_BITS'(1);
                  wr_c.en         = 1'b1;
                  wr_c.data.count = res_c.count_now;
               end else if (req_ff.wait_mode == WAIT_NONE) begin
                  res_c.status = ST_BUSY;
               end else if (req_ff.wait_mode == WAIT_BOUNDED &&
                            req_ff.elapsed_ticks >= req_ff.tick_limit) begin
                  res_c.status = ST_TIMEOUT;
               end else begin
                  res_c.status              = ST_PENDING;
                  wr_c.en                   = 1'b1;
                  wr_c.data.wait_task       = req_ff.task_id;
                  waiting_in[req_ff.handle] = 1'b1;
               end
            end
         end
         CMD_GIVE: begin
            if (slot_ok) begin
               res_c.count_now = rd_data.count;
               if (rd_data.count < rd_data.ceiling) begin
                  res_c.status    = ST_OK;
                  res_c.count_now = rd_data.count + COUNT_BITS'(1);
                  wr_c.en         = 1'b1;
                  wr_c.data.count = res_c.count_now;
                  if (waiting_ff[req_ff.handle]) begin
                     res_c.woke_waiter         = 1'b1;
                     res_c.wake_task           = rd_data.wait_task;
                     waiting_in[req_ff.handle] = 1'b0;
                  end
               end else begin
                  res_c.status = ST_OVERFLOW;
               end
            end
         end
         CMD_DESTROY: begin
            if (slot_ok) begin
               res_c.status           = ST_OK;
               used_in[req_ff.handle] = 1'b0;
            end
         end
         default: begin
            res_c.status = ST_INVALID;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               req_in   = req;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         waiting_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            used_ff    <= used_in;
            waiting_ff <= waiting_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign res_valid = fire;
   assign res       = res_c;
   assign wr.en     = wr_c.en && fire;
   assign wr.addr   = wr_c.addr;
   assign wr.data   = wr_c.data;

`include "counting_semaphore_table_unit_assert.svh"

   `CSEM_ASSERT(a_write_in_exec, wr.en |-> (state_ff == ST_EXEC), "memory write outside exec")
   `CSEM_ASSERT(a_accept_to_exec, accept |=> (state_ff == ST_EXEC), "accepted request not executed")
   `CSEM_ASSERT(a_pending_sets_waiter, (fire && res_c.status == ST_PENDING) |=> waiting_ff[$past(req_ff.handle)], "pending take left no waiter")
   `CSEM_ASSERT(a_wake_on_give, (fire && res_c.woke_waiter) |-> (req_ff.cmd == CMD_GIVE && res_c.status == ST_OK), "wake outside a successful give")
   `CSEM_ASSERT_ALWAYS(a_no_result_in_reset, reset |=> !res_valid, "result right after reset")

endmodule
`default_nettype wire

>>> hdl/counting_semaphore_table_unit.sv
// the request and its slot read are registered; the response enters the output register when free
// a new request is taken only after the previous one has written back and left the exec state
// a new request is taken while an earlier response still waits on the rsp side
// reset (synchronous, active high) frees all slots and waiters; no clearing pass, ready at once
// slot count, ceiling and waiter memory contents are not cleared: only read behind valid flags
`default_nettype none
module counting_semaphore_table_unit
   import csem_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cmd[1:0], handle[5:2], init_count[21:6], ceil_count[37:22], wait_mode[39:38],
   // tick_limit[71:40], elapsed_ticks[103:72], task_id[111:104]
   input  wire logic [111:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], new_handle[6:3], woke_waiter[7], wake_task[15:8], count_now[31:16]
   output logic [31:0]       rsp_tdata
);

   req_type    req;
   rsp_type    res;
   logic       res_valid;
   logic       out_free;
   logic       rd_en;
   logic [SLOT_BITS-1:0] rd_addr;
   entry_type  rd_data;
   mem_wr_type wr;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign req      = req_type'(req_tdata);
   assign out_free = !rsp_valid_ff || rsp_tready;

   csem_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr        (wr)
   );

   csem_store u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 32'(rsp_data_ff);

endmodule
`default_nettype wire

>>> sim/csem_checker.sv
// response checker for the counting semaphore table: tracks slot state and compares every response
module csem_checker
   import csem_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [111:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [31:0]  rsp_tdata,
   output int                fail_count,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic                  slot_live   [SLOTS];
   logic [COUNT_BITS-1:0] live_count  [SLOTS];
   logic [COUNT_BITS-1:0] live_ceiling[SLOTS];
   logic                  waiter_set  [SLOTS];
   logic [TASK_BITS-1:0]  waiter_id   [SLOTS];

   rsp_type expected_rsp_q[$];
   int      rsp_seen;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] response %0d: %s got 0x%0h, expected 0x%0h",
               $realtime, rsp_seen, what, got, want);
      fail_count++;
   endtask

   // applies one request to the slot table and returns the response it must produce
   function automatic rsp_type apply_command(input req_type r);
      rsp_type res;
      int      free_slot;
      res        = '0;
      res.status = ST_INVALID;
      free_slot  = -1;
      if (r.cmd == CMD_CREATE) begin
         if (r.ceil_count != '0 && r.init_count <= r.ceil_count) begin
            res.status = ST_NOMEM;
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!slot_live[i]) free_slot = i;
            end
            if (free_slot >= 0) begin
               slot_live[free_slot]    = 1'b1;
               live_count[free_slot]   = r.init_count;
               live_ceiling[free_slot] = r.ceil_count;
               waiter_set[free_slot]   = 1'b0;
               res.status              = ST_OK;
               res.new_handle          = SLOT_BITS'(free_slot);
               res.count_now           = r.init_count;
            end
         end
      end else if (slot_live[r.handle]) begin
         case (r.cmd)
            CMD_TAKE: begin
               if (live_count[r.handle] != '0) begin
                  live_count[r.handle] = live_count[r.handle] - COUNT_BITS'(1);
                  res.status = ST_OK;
               end else if (r.wait_mode == WAIT_NONE) begin
                  res.status = ST_BUSY;
               end else if (r.wait_mode == WAIT_BOUNDED
                            && r.elapsed_ticks >= r.tick_limit) begin
                  res.status = ST_TIMEOUT;
               end else begin
                  // other modes wait forever, bounded with time left too: caller becomes waiter
                  waiter_set[r.handle] = 1'b1;
                  waiter_id[r.handle]  = r.task_id;
                  res.status = ST_PENDING;
               end
               res.count_now = live_count[r.handle];
            end
            CMD_GIVE: begin
               if (live_count[r.handle] < live_ceiling[r.handle]) begin
                  live_count[r.handle] = live_count[r.handle] + COUNT_BITS'(1);
                  if (waiter_set[r.handle]) begin
                     res.woke_waiter = 1'b1;
                     res.wake_task   = waiter_id[r.handle];
                     waiter_set[r.handle] = 1'b0;
                  end
                  res.status = ST_OK;
               end else begin
                  res.status = ST_OVERFLOW;
               end
               res.count_now = live_count[r.handle];
            end
            default: begin
               slot_live[r.handle] = 1'b0;
               res.status = ST_OK;
            end
         endcase
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            waiter_set[i] = 1'b0;
         end
         expected_rsp_q.delete();
         rsp_seen = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(apply_command(req_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata);
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response with no request waiting:", got, '0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.new_handle !== want.new_handle)
                  report_mismatch("new_handle", 32'(got.new_handle), 32'(want.new_handle));
               if (got.woke_waiter !== want.woke_waiter)
                  report_mismatch("woke_waiter", 32'(got.woke_waiter), 32'(want.woke_waiter));
               if (got.wake_task !== want.wake_task)
                  report_mismatch("wake_task", 32'(got.wake_task), 32'(want.wake_task));
               if (got.count_now !== want.count_now)
                  report_mismatch("count_now", 32'(got.count_now), 32'(want.count_now));
            end
            rsp_seen++;
         end
      end
      outstanding <= expected_rsp_q.size();
   end

endmodule

>>> sim/counting_semaphore_table_unit_tb.sv
// testbench top for the counting semaphore table: clock, reset, request traffic and verdict
module counting_semaphore_table_unit_tb;
   import csem_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] WAIT_FOREVER = 2'd2;
   localparam logic [1:0] WAIT_SPARE   = 2'd3;

   localparam int RANDOM_ITEMS   = 1600;
   localparam int BACKLOG_AT     = 400;
   localparam int DRAIN_AT       = 900;
   localparam int BACKLOG_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 10;
   localparam int CYCLE_LIMIT    = 500000;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         backlog_go = 1'b0;

   int fail_count;
   int outstanding;
   int burst_left = 0;
   int cycle_count = 0;

   counting_semaphore_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   csem_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   function automatic req_type build(input logic [1:0] cmd, input logic [SLOT_BITS-1:0] handle,
                                     input logic [COUNT_BITS-1:0] init,
                                     input logic [COUNT_BITS-1:0] ceil,
                                     input logic [1:0] mode, input logic [TICK_BITS-1:0] tmo,
                                     input logic [TICK_BITS-1:0] elapsed,
                                     input logic [TASK_BITS-1:0] task_id);
      req_type r;
      r.cmd           = cmd;
      r.handle        = handle;
      r.init_count    = init;
      r.ceil_count    = ceil;
      r.wait_mode     = mode;
      r.tick_limit    = tmo;
      r.elapsed_ticks = elapsed;
      r.task_id       = task_id;
      return r;
   endfunction

   // mostly small ceilings so counts hit zero and the ceiling often; unused fields stay random
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      int unsigned flavor;
      r = build(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 16'($urandom),
                16'($urandom), 2'($urandom_range(0, 3)), $urandom, $urandom, 8'($urandom));
      pick   = $urandom_range(0, 99);
      flavor = $urandom_range(0, 9);
      if (pick < 20) begin
         r.cmd = CMD_CREATE;
         if (flavor <= 6) begin
            r.ceil_count = 16'($urandom_range(1, 4));
            r.init_count = 16'($urandom_range(0, r.ceil_count));
         end else if (flavor == 7) begin
            r.ceil_count = '1;
            r.init_count = 16'($urandom_range(65533, 65535));
         end else if (flavor == 9) begin
            if ($urandom_range(0, 1) == 1) begin
               r.ceil_count = '0;
            end else begin
               r.ceil_count = 16'($urandom_range(0, 65534));
               r.init_count = 16'($urandom_range(r.ceil_count + 1, 65535));
            end
         end
      end else if (pick < 58) begin
         r.cmd = CMD_TAKE;
         if (flavor < 6) begin
            r.tick_limit    = $urandom_range(0, 3);
            r.elapsed_ticks = $urandom_range(0, 3);
         end
      end else if (pick < 88) begin
         r.cmd = CMD_GIVE;
      end else begin
         r.cmd = CMD_DESTROY;
      end
      return r;
   endfunction

   // sender offers requests in bursts with random gaps in between
   task automatic send_request(input req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   initial begin : rsp_side
      int unsigned beat;
      int unsigned style;
      logic        backlog_done;
      beat         = 0;
      style        = 0;
      backlog_done = 1'b0;
      forever begin
         @(posedge clock);
         // one long hold-off so the block backs up and stalls its request side
         if (backlog_go && !backlog_done) begin
            rsp_tready <= 1'b0;
            repeat (BACKLOG_CYCLES) @(posedge clock);
            backlog_done = 1'b1;
         end
         if (beat % 96 == 0) style = $urandom_range(0, 3);
         case (style)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            2:       rsp_tready <= (beat % 5 != 0);
            default: rsp_tready <= (beat % 16 >= 10);
         endcase
         beat++;
      end
   end

   initial begin : req_side
      req_type directed_q[$];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // free slots, bad create arguments, then the take and give paths on two slots
      directed_q.push_back(build(CMD_TAKE,    4'd0,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_DESTROY, 4'd15, 16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_CREATE,  4'd0,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_CREATE,  4'd0,  16'd5, 16'd4, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_CREATE,  4'd0,  16'd0, 16'd1, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_CREATE,  4'd0,  16'hFFFF, 16'hFFFF, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_TAKE,    4'd0,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h11));
      directed_q.push_back(build(CMD_TAKE,    4'd0,  16'd0, 16'd0, WAIT_BOUNDED,
                                 '1, '1, 8'h22));
      directed_q.push_back(build(CMD_TAKE,    4'd0,  16'd0, 16'd0, WAIT_BOUNDED,
                                 32'd10, 32'd9, 8'hA5));
      directed_q.push_back(build(CMD_TAKE,    4'd0,  16'd0, 16'd0, WAIT_SPARE, 0, 0, 8'h5A));
      directed_q.push_back(build(CMD_GIVE,    4'd0,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_GIVE,    4'd0,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_TAKE,    4'd0,  16'd0, 16'd0, WAIT_FOREVER, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_TAKE,    4'd0,  16'd0, 16'd0, WAIT_FOREVER, 0, 0, 8'hFF));
      directed_q.push_back(build(CMD_GIVE,    4'd1,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_TAKE,    4'd1,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      // destroy with a waiter recorded, recreate: the old waiter must not wake
      directed_q.push_back(build(CMD_DESTROY, 4'd0,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_GIVE,    4'd0,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_CREATE,  4'd0,  16'd2, 16'd3, WAIT_NONE, 0, 0, 8'h00));
      directed_q.push_back(build(CMD_GIVE,    4'd0,  16'd0, 16'd0, WAIT_NONE, 0, 0, 8'h00));
      // fill the remaining slots, then one more create finds the table full
      for (int i = 0; i < 15; i++)
         directed_q.push_back(build(CMD_CREATE, 4'd0, 16'($urandom), 16'hFFFF, WAIT_NONE,
                                    0, 0, 8'h00));
      foreach (directed_q[i]) send_request(directed_q[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == BACKLOG_AT) backlog_go <= 1'b1;
         if (n == DRAIN_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
            burst_left = 0;
         end
         send_request(random_request());
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> counting_semaphore_table_unit.f
+incdir+hdl
hdl/csem_pkg.sv
hdl/csem_store.sv
hdl/csem_engine.sv
hdl/counting_semaphore_table_unit.sv
sim/csem_checker.sv
sim/counting_semaphore_table_unit_tb.sv
